>>> sv/assert_macros.svh
// Assertion helpers for the RTL, included by array_mode_by_merge_sort_core.
// Every check samples on the rising edge of i_clk and is disabled while
// i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every sampled clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/amms_pkg.sv
// ----------------------------------------------------------------------------
// amms_pkg
// Shared types and constants of the mode-by-merge-sort core.
// ----------------------------------------------------------------------------
package amms_pkg;

    // Sequencer states of the core.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SEG,
        ST_PRIME0,
        ST_PRIME1,
        ST_MERGE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Control of the run-length scanner, one element per strobe.
    typedef struct packed {
        logic vld;
        logic first;
    } t_scan_ctl;

    localparam int OUT_CNT_W = 7;
    localparam logic [OUT_CNT_W-1:0] COUNT_SAT = 7'd127;

endpackage

>>> sv/amms_ram.sv
// ----------------------------------------------------------------------------
// amms_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module amms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/amms_scan.sv
// ----------------------------------------------------------------------------
// amms_scan
// Run-length tracker over a sorted stream; keeps the longest run seen.
// ----------------------------------------------------------------------------
module amms_scan
    import amms_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int CNT_WIDTH   = 7
) (
    input  logic                   i_clk,
    input  t_scan_ctl              i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_data,
    output logic [VALUE_WIDTH-1:0] o_mode_value,
    output logic [CNT_WIDTH-1:0]   o_mode_run
);

    logic [VALUE_WIDTH-1:0] r_cur, n_cur;
    logic [VALUE_WIDTH-1:0] r_best, n_best;
    logic [CNT_WIDTH-1:0]   r_run, n_run;
    logic [CNT_WIDTH-1:0]   r_best_run, n_best_run;

    always_comb begin
        n_cur      = r_cur;
        n_best     = r_best;
        n_run      = r_run;
        n_best_run = r_best_run;
        if (i_ctl.vld) begin
            if (i_ctl.first) begin
                n_cur      = i_data;
                n_best     = i_data;
                n_run      = CNT_WIDTH'(1);
                n_best_run = CNT_WIDTH'(1);
            end else if (i_data == r_cur) begin
                n_run = r_run + CNT_WIDTH'(1);
            end else begin
                // strict compare: the earlier (smaller) value keeps a tie
                if (r_run > r_best_run) begin
                    n_best_run = r_run;
                    n_best     = r_cur;
                end
                n_cur = i_data;
                n_run = CNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_best     <= n_best;
        r_run      <= n_run;
        r_best_run <= n_best_run;
    end

    // close the final run
    assign o_mode_value = (r_run > r_best_run) ? r_cur : r_best;
    assign o_mode_run   = (r_run > r_best_run) ? r_run : r_best_run;

endmodule

>>> sv/array_mode_by_merge_sort_core.sv
// ----------------------------------------------------------------------------
// array_mode_by_merge_sort_core
// Collects a set of signed samples, sorts it with a bottom-up merge sort
// between two RAMs, then scans the sorted runs and reports the mode.
// ----------------------------------------------------------------------------
// Load: one cycle per sample; the input is held off from the last sample on.
// The sort takes ceil(log2 n) merge passes (n - 1 segments in all for a power
//   of two n); the finished result waits in ST_DONE while an earlier one is
//   not yet taken. Reset (synchronous, active low) empties the set.
// Merging reads through the single source read port, one element per cycle;
//   each segment is first set up in ST_SEG, ST_PRIME0 and ST_PRIME1.
module array_mode_by_merge_sort_core
    import amms_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // sample channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [VALUE_WIDTH-1:0] i_sample_value,
    input  logic                   i_is_last,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [VALUE_WIDTH-1:0] o_mode_value,
    output logic [OUT_CNT_W-1:0]   o_mode_count,
    output logic                   o_overflow
);

    `include "assert_macros.svh"

    localparam int CW = $clog2(MAX_ELEMENTS + 1);   // counts up to the capacity
    localparam int AW = $clog2(MAX_ELEMENTS);       // RAM address

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;       // samples stored so far
    logic                r_ovf_seen, n_ovf_seen;
    logic [CW-1:0]       r_n, n_n;               // size of the closed set
    logic                r_ovf, n_ovf;           // overflow of the closed set
    logic [CW:0]         r_w, n_w;               // run width of this pass
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_mid, n_mid;
    logic [CW-1:0]       r_hi, n_hi;
    logic [CW-1:0]       r_a, n_a;               // left run read pointer
    logic [CW-1:0]       r_b, n_b;               // right run read pointer
    logic [CW-1:0]       r_k, n_k;               // write pointer
    logic [VALUE_WIDTH-1:0] r_ha, n_ha;          // held heads of both runs
    logic [VALUE_WIDTH-1:0] r_hb, n_hb;
    logic                r_pa, n_pa;             // head arrives on read data
    logic                r_pb, n_pb;
    logic                r_src, n_src;           // RAM that holds the source
    logic [CW-1:0]       r_i, n_i;               // scan read pointer
    logic                r_dv, n_dv;             // scan read data valid
    logic                r_first, n_first;
    logic                r_out_valid, n_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_value, n_out_value;
    logic [OUT_CNT_W-1:0] r_out_count, n_out_count;
    logic                r_out_ovf, n_out_ovf;

    // ------------------------------------------------------------------
    // RAM ports and shared merge signals
    // ------------------------------------------------------------------
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data, rd_data0, rd_data1;
    logic                   load_we;
    logic                   sort_we;
    logic                   we0, we1;
    logic [AW-1:0]          waddr0, waddr1;
    logic [VALUE_WIDTH-1:0] wdata0, wdata1;

    logic                   in_acc;
    logic                   has_room;
    logic [VALUE_WIDTH-1:0] eff_a, eff_b, pick;
    logic                   a_ok, b_ok, take_a;
    logic [CW:0]            a_nx, b_nx, k_nx;
    logic                   a_more, b_more;
    logic                   seg_end, pass_end, sort_done;
    logic [CW:0]            lo_w, lo_2w;
    logic                   scan_end, out_free;

    t_scan_ctl              scan_ctl;
    logic [VALUE_WIDTH-1:0] scan_value;
    logic [CW-1:0]          scan_run;

    assign in_acc   = i_in_valid && o_in_ready;
    assign has_room = r_count < CW'(MAX_ELEMENTS);
    assign rd_data  = r_src ? rd_data1 : rd_data0;

    // merge: a head that was just fetched comes straight from the read data
    assign eff_a  = r_pa ? rd_data : r_ha;
    assign eff_b  = r_pb ? rd_data : r_hb;
    assign a_ok   = r_a < r_mid;
    assign b_ok   = r_b < r_hi;
    // left run wins ties to keep the sort stable
    assign take_a = a_ok && (!b_ok || ($signed(eff_a) <= $signed(eff_b)));
    assign pick   = take_a ? eff_a : eff_b;
    assign a_nx   = {1'b0, r_a} + (CW+1)'(1);
    assign b_nx   = {1'b0, r_b} + (CW+1)'(1);
    assign k_nx   = {1'b0, r_k} + (CW+1)'(1);
    assign a_more = a_nx < {1'b0, r_mid};
    assign b_more = b_nx < {1'b0, r_hi};
    assign seg_end  = k_nx == {1'b0, r_hi};
    assign pass_end = r_hi == r_n;
    assign sort_done = r_w >= {1'b0, r_n};

    assign lo_w  = {1'b0, r_lo} + r_w;
    assign lo_2w = {1'b0, r_lo} + {r_w[CW-1:0], 1'b0};

    assign scan_end = (r_i == r_n) && !r_dv;
    assign out_free = !r_out_valid || i_out_ready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (in_acc && i_is_last) begin
                    n_state = ST_SEG;
                end
            end
            ST_SEG: begin
                n_state = sort_done ? ST_SCAN : ST_PRIME0;
            end
            ST_PRIME0: begin
                n_state = ST_PRIME1;
            end
            ST_PRIME1: begin
                n_state = ST_MERGE;
            end
            ST_MERGE: begin
                if (seg_end) begin
                    n_state = ST_SEG;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs: handshake and RAM strobes
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready = 1'b0;
        load_we    = 1'b0;
        sort_we    = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_a[AW-1:0];
        scan_ctl   = '0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                load_we    = in_acc && has_room;
            end
            ST_PRIME0: begin
                rd_en   = 1'b1;
                rd_addr = r_a[AW-1:0];
            end
            ST_PRIME1: begin
                rd_en   = b_ok;
                rd_addr = r_b[AW-1:0];
            end
            ST_MERGE: begin
                sort_we = 1'b1;
                rd_en   = take_a ? a_more : b_more;
                rd_addr = take_a ? a_nx[AW-1:0] : b_nx[AW-1:0];
            end
            ST_SCAN: begin
                rd_en          = r_i < r_n;
                rd_addr        = r_i[AW-1:0];
                scan_ctl.vld   = r_dv;
                scan_ctl.first = r_first;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // load always fills RAM 0; the sort ping-pongs between the two RAMs
    assign we0    = load_we || (sort_we && r_src);
    assign waddr0 = load_we ? r_count[AW-1:0] : r_k[AW-1:0];
    assign wdata0 = load_we ? i_sample_value : pick;
    assign we1    = sort_we && !r_src;
    assign waddr1 = r_k[AW-1:0];
    assign wdata1 = pick;

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_comb begin
        n_count     = r_count;
        n_ovf_seen  = r_ovf_seen;
        n_n         = r_n;
        n_ovf       = r_ovf;
        n_w         = r_w;
        n_lo        = r_lo;
        n_mid       = r_mid;
        n_hi        = r_hi;
        n_a         = r_a;
        n_b         = r_b;
        n_k         = r_k;
        n_ha        = r_ha;
        n_hb        = r_hb;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_src       = r_src;
        n_i         = r_i;
        n_dv        = r_dv;
        n_first     = r_first;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_value = r_out_value;
        n_out_count = r_out_count;
        n_out_ovf   = r_out_ovf;
        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    // drop a sample that finds the store full
                    if (has_room) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf_seen = 1'b1;
                    end
                    if (i_is_last) begin
                        n_n        = has_room ? (r_count + CW'(1)) : r_count;
                        n_ovf      = r_ovf_seen || !has_room;
                        n_count    = '0;
                        n_ovf_seen = 1'b0;
                        n_w        = (CW+1)'(1);
                        n_lo       = '0;
                        n_src      = 1'b0;
                    end
                end
            end
            ST_SEG: begin
                // clip both run bounds to the set size
                n_mid   = (lo_w < {1'b0, r_n}) ? lo_w[CW-1:0] : r_n;
                n_hi    = (lo_2w < {1'b0, r_n}) ? lo_2w[CW-1:0] : r_n;
                n_a     = r_lo;
                n_b     = (lo_w < {1'b0, r_n}) ? lo_w[CW-1:0] : r_n;
                n_k     = r_lo;
                n_i     = '0;
                n_dv    = 1'b0;
                n_first = 1'b1;
            end
            ST_PRIME1: begin
                n_ha = rd_data;
                n_pa = 1'b0;
                n_pb = b_ok;
            end
            ST_MERGE: begin
                n_k = k_nx[CW-1:0];
                if (take_a) begin
                    n_a  = a_nx[CW-1:0];
                    n_pa = a_more;
                    n_pb = 1'b0;
                    n_hb = eff_b;
                end else begin
                    n_b  = b_nx[CW-1:0];
                    n_pb = b_more;
                    n_pa = 1'b0;
                    n_ha = eff_a;
                end
                if (seg_end) begin
                    if (pass_end) begin
                        // swap RAM roles and double the run width
                        n_w   = {r_w[CW-1:0], 1'b0};
                        n_lo  = '0;
                        n_src = !r_src;
                    end else begin
                        n_lo = r_hi;
                    end
                end
            end
            ST_SCAN: begin
                if (r_i < r_n) begin
                    n_i = r_i + CW'(1);
                end
                n_dv = r_i < r_n;
                if (r_dv) begin
                    n_first = 1'b0;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = scan_value;
                    n_out_ovf   = r_ovf;
                    // saturate the run length at the port's range
                    if (32'(scan_run) > 32'(COUNT_SAT)) begin
                        n_out_count = COUNT_SAT;
                    end else begin
                        n_out_count = OUT_CNT_W'(scan_run);
                    end
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_out_ready;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf_seen  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pa        <= 1'b0;
            r_pb        <= 1'b0;
            r_dv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf_seen  <= n_ovf_seen;
            r_out_valid <= n_out_valid;
            r_pa        <= n_pa;
            r_pb        <= n_pb;
            r_dv        <= n_dv;
        end
    end

    // payload and pointer registers, always written before use
    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_ovf       <= n_ovf;
        r_w         <= n_w;
        r_lo        <= n_lo;
        r_mid       <= n_mid;
        r_hi        <= n_hi;
        r_a         <= n_a;
        r_b         <= n_b;
        r_k         <= n_k;
        r_ha        <= n_ha;
        r_hb        <= n_hb;
        r_src       <= n_src;
        r_i         <= n_i;
        r_first     <= n_first;
        r_out_value <= n_out_value;
        r_out_count <= n_out_count;
        r_out_ovf   <= n_out_ovf;
    end

    // ------------------------------------------------------------------
    // Instances
    // ------------------------------------------------------------------
    amms_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (waddr0),
        .i_wdata (wdata0),
        .i_re    (rd_en && !r_src),
        .i_raddr (rd_addr),
        .o_rdata (rd_data0)
    );

    amms_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_ELEMENTS)
    ) u_scratch (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr1),
        .i_wdata (wdata1),
        .i_re    (rd_en && r_src),
        .i_raddr (rd_addr),
        .o_rdata (rd_data1)
    );

    amms_scan #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .CNT_WIDTH   (CW)
    ) u_scan (
        .i_clk        (i_clk),
        .i_ctl        (scan_ctl),
        .i_data       (rd_data),
        .o_mode_value (scan_value),
        .o_mode_run   (scan_run)
    );

    assign o_out_valid  = r_out_valid;
    assign o_mode_value = r_out_value;
    assign o_mode_count = r_out_count;
    assign o_overflow   = r_out_ovf;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_count_cap, r_count <= CW'(MAX_ELEMENTS), "sample count above capacity")
    `ASSERT_ALWAYS(a_one_pending, !(r_pa && r_pb), "both run heads pending on one read")
    `ASSERT_IMPLIES(a_merge_bound, r_state == ST_MERGE,
        r_k < r_hi && (a_ok || b_ok), "merge write beyond its segment")
    `ASSERT_NEXT(a_scan_start, r_state == ST_SEG && sort_done,
        r_state == ST_SCAN && r_i == '0 && r_first, "scan does not start at the first element")

endmodule
